// ===== hw/rtl/tid_pkg.sv =====
// Types and codes shared by the target ID allocator.
`timescale 1ns / 1ps
`default_nettype none
package tid_pkg;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_USE   = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_FIND  = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		KIND_ANSWER   = 1'b0,
		KIND_RENUMBER = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN,
		ST_CWALK,
		ST_CMOVE,
		ST_GRANT,
		ST_OPEN
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] handle;
		logic [7:0]  id;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  id_res;
		logic [7:0]  old_id;
		logic [15:0] handle_res;
		logic        found;
		logic        last;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tid_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module tid_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/target_id_allocator.sv =====
// Paged ID allocator with compaction: top level.
//
// Usage: drive req and raise start; the request is taken at a clock edge
// where start is high and busy is low. Every request yields one or more
// results on rsp, each shown for one cycle with done high; the receiver
// cannot stall them. Renumber notices (kind 1) from compaction come first,
// the answer (last 1) always closes the request.
// Free, and use on a free slot: the answer is shown in the cycle after
// acceptance, busy stays low. Find: passes through the FIND state (handle
// memory read). Allocate: scans pages (up to PAGES-1), then, when the chosen
// page is compacted, walks it (CWALK, with a CMOVE step per moved entry),
// then grants or opens a page; the answer is shown in the same cycle in
// which busy falls.
// The handle store is a single RAM with registered read; the used bits (one
// word per page) and page state are flip-flops. Reset clears all page and
// slot state at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module target_id_allocator #(
	parameter int SLOTS_PER_PAGE = 32,
	parameter int PAGES          = 8,
	parameter int HANDLE_BITS    = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire tid_pkg::req_t req,
	output logic               done,
	output tid_pkg::rsp_t      rsp
);
	import tid_pkg::*;

	localparam int NSLOTS = PAGES * SLOTS_PER_PAGE;
	localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int PW     = $clog2(PAGES);
	localparam int CW     = $clog2(SLOTS_PER_PAGE + 1);
	localparam int SW     = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;

	state_t state_q, state_d;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic hit_q;
	logic [PW-1:0] scan_q, spare_q;
	logic spare_ok_q;
	logic [CW-1:0] head_q, tail_q;
	logic [SLOTS_PER_PAGE-1:0] used_q [PAGES];
	logic [PAGES-1:0] open_q;
	logic [CW-1:0] cnt_q [PAGES];
	logic [CW-1:0] mark_q [PAGES];
	logic done_q;
	rsp_t rsp_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [HANDLE_BITS-1:0] ram_wdata, ram_rdata;

	function automatic logic [PW-1:0] page_of(input logic [7:0] v);
		logic [PW-1:0] pg;
		pg = '0;
		for (int k = 1; k < PAGES; k++) begin
			if (32'(v) >= k * SLOTS_PER_PAGE) begin
				pg = PW'(k);
			end
		end
		return pg;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] pg,
		input logic [CW-1:0] sl);
		return AW'(32'(pg) * SLOTS_PER_PAGE + 32'(sl));
	endfunction

	function automatic logic [7:0] id8(input logic [AW-1:0] a);
		return 8'(32'(a));
	endfunction

	function automatic rsp_t answer(input logic [7:0] g, input logic [15:0] h,
		input logic f);
		rsp_t r;
		r.kind       = KIND_ANSWER;
		r.id_res     = g;
		r.old_id     = '0;
		r.handle_res = h;
		r.found      = f;
		r.last       = 1'b1;
		return r;
	endfunction

	logic in_valid;
	logic [PW-1:0] in_pg;
	logic [CW-1:0] in_sl;
	logic [SW-1:0] in_sx;
	logic [AW-1:0] in_slot;
	logic [HANDLE_BITS-1:0] in_hdl;
	logic in_hit;
	logic accept;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_valid = (req.id != 8'd0) && (32'(req.id) <= NSLOTS - 1);
	assign in_pg    = in_valid ? page_of(req.id) : '0;
	assign in_sl    = in_valid ? CW'(32'(req.id) - 32'(in_pg) * SLOTS_PER_PAGE) : '0;
	assign in_sx    = SW'(in_sl);
	assign in_slot  = addr_of(in_pg, in_sl);
	assign in_hdl   = HANDLE_BITS'(32'(req.handle));
	assign in_hit   = in_valid && open_q[in_pg] && used_q[in_pg][in_sx];

	logic [AW-1:0] scan_grant_addr, head_addr, tail_addr, spare_addr;
	logic [SW-1:0] head_sx, tail_sx, mark_sx;
	logic last_page;
	logic spare_now_ok;

	assign scan_grant_addr = addr_of(scan_q, mark_q[scan_q]);
	assign head_addr       = addr_of(scan_q, head_q);
	assign tail_addr       = addr_of(scan_q, tail_q);
	assign spare_addr      = addr_of(spare_q, '0);
	assign head_sx         = SW'(head_q);
	assign tail_sx         = SW'(tail_q);
	assign mark_sx         = SW'(mark_q[scan_q]);
	assign last_page       = (32'(scan_q) == PAGES - 1);
	assign spare_now_ok    = spare_ok_q || !open_q[scan_q];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(req.command))
						CMD_ALLOC: state_d = ST_SCAN;
						CMD_USE:   state_d = (in_valid && !(open_q[in_pg] && used_q[in_pg][in_sx]))
							? ST_IDLE : ST_SCAN;
						CMD_FIND:  state_d = ST_FIND;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_FIND: state_d = ST_IDLE;
			ST_SCAN: begin
				if (open_q[scan_q] && 32'(cnt_q[scan_q]) < SLOTS_PER_PAGE) begin
					state_d = (32'(mark_q[scan_q]) >= SLOTS_PER_PAGE) ? ST_CWALK : ST_GRANT;
				end else if (last_page) begin
					state_d = spare_now_ok ? ST_OPEN : ST_IDLE;
				end
			end
			ST_CWALK: begin
				if (32'(head_q) == SLOTS_PER_PAGE) begin
					state_d = ST_GRANT;
				end else if (used_q[scan_q][head_sx] && head_q != tail_q) begin
					state_d = ST_CMOVE;
				end
			end
			ST_CMOVE: state_d = ST_CWALK;
			ST_GRANT: state_d = ST_IDLE;
			ST_OPEN:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = in_slot;
		ram_wdata = hdl_q;
		ram_raddr = head_addr;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = in_slot;
				ram_wdata = in_hdl;
				ram_we    = accept && (cmd_t'(req.command) == CMD_USE) && (state_d == ST_IDLE);
			end
			ST_CMOVE: begin
				ram_we    = 1'b1;
				ram_waddr = tail_addr;
				ram_wdata = ram_rdata;
			end
			ST_GRANT: begin
				ram_we    = 1'b1;
				ram_waddr = scan_grant_addr;
			end
			ST_OPEN: begin
				ram_we    = 1'b1;
				ram_waddr = spare_addr;
			end
			default: ram_we = 1'b0;
		endcase
	end

	tid_ram #(
		.WIDTH(HANDLE_BITS),
		.DEPTH(NSLOTS)
	) u_handle_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			open_q     <= '0;
			done_q     <= 1'b0;
			spare_ok_q <= 1'b0;
			for (int k = 0; k < PAGES; k++) begin
				used_q[k] <= '0;
				cnt_q[k]  <= '0;
				mark_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hdl_q      <= in_hdl;
						hit_q      <= in_hit;
						scan_q     <= PW'(1);
						spare_ok_q <= 1'b0;
						case (cmd_t'(req.command))
							CMD_USE: begin
								if (in_valid && !open_q[in_pg]) begin
									used_q[in_pg] <= SLOTS_PER_PAGE'(1) << in_sx;
									open_q[in_pg] <= 1'b1;
									cnt_q[in_pg]  <= CW'(1);
									mark_q[in_pg] <= in_sl + CW'(1);
									done_q <= 1'b1;
									rsp_q  <= answer(req.id, 16'd0, 1'b0);
								end else if (in_valid && !used_q[in_pg][in_sx]) begin
									used_q[in_pg][in_sx] <= 1'b1;
									cnt_q[in_pg] <= cnt_q[in_pg] + CW'(1);
									if (mark_q[in_pg] <= in_sl) begin
										mark_q[in_pg] <= in_sl + CW'(1);
									end
									done_q <= 1'b1;
									rsp_q  <= answer(req.id, 16'd0, 1'b0);
								end
							end
							CMD_FREE: begin
								if (in_hit) begin
									used_q[in_pg][in_sx] <= 1'b0;
									cnt_q[in_pg] <= cnt_q[in_pg] - CW'(1);
									if (cnt_q[in_pg] == CW'(1)) begin
										open_q[in_pg] <= 1'b0;
										mark_q[in_pg] <= '0;
									end else if (mark_q[in_pg] == in_sl + CW'(1)) begin
										mark_q[in_pg] <= in_sl;
									end
								end
								done_q <= 1'b1;
								rsp_q  <= answer(8'd0, 16'd0, 1'b0);
							end
							default: ;
						endcase
					end
				end
				ST_FIND: begin
					done_q <= 1'b1;
					rsp_q  <= answer(8'd0, hit_q ? 16'(32'(ram_rdata)) : 16'd0, hit_q);
				end
				ST_SCAN: begin
					if (!open_q[scan_q] && !spare_ok_q) begin
						spare_q    <= scan_q;
						spare_ok_q <= 1'b1;
					end
					if (state_d == ST_CWALK) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (state_d == ST_IDLE) begin
						done_q <= 1'b1;
						rsp_q  <= answer(8'd0, 16'd0, 1'b0);
					end else if (state_d == ST_SCAN) begin
						scan_q <= scan_q + PW'(1);
					end
				end
				ST_CWALK: begin
					if (32'(head_q) == SLOTS_PER_PAGE) begin
						mark_q[scan_q] <= tail_q;
					end else if (!used_q[scan_q][head_sx]) begin
						head_q <= head_q + CW'(1);
					end else if (head_q == tail_q) begin
						head_q <= head_q + CW'(1);
						tail_q <= tail_q + CW'(1);
					end
				end
				ST_CMOVE: begin
					used_q[scan_q] <= (used_q[scan_q] | (SLOTS_PER_PAGE'(1) << tail_sx))
						& ~(SLOTS_PER_PAGE'(1) << head_sx);
					head_q <= head_q + CW'(1);
					tail_q <= tail_q + CW'(1);
					done_q <= 1'b1;
					rsp_q.kind       <= KIND_RENUMBER;
					rsp_q.id_res     <= id8(tail_addr);
					rsp_q.old_id     <= id8(head_addr);
					rsp_q.handle_res <= 16'(32'(ram_rdata));
					rsp_q.found      <= 1'b0;
					rsp_q.last       <= 1'b0;
				end
				ST_GRANT: begin
					used_q[scan_q][mark_sx] <= 1'b1;
					cnt_q[scan_q]  <= cnt_q[scan_q] + CW'(1);
					mark_q[scan_q] <= mark_q[scan_q] + CW'(1);
					done_q <= 1'b1;
					rsp_q  <= answer(id8(scan_grant_addr), 16'd0, 1'b0);
				end
				ST_OPEN: begin
					used_q[spare_q] <= SLOTS_PER_PAGE'(1);
					open_q[spare_q] <= 1'b1;
					cnt_q[spare_q]  <= CW'(1);
					mark_q[spare_q] <= CW'(1);
					done_q <= 1'b1;
					rsp_q  <= answer(id8(spare_addr), 16'd0, 1'b0);
				end
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = done_q;
		rsp  = rsp_q;
	end
endmodule
`default_nettype wire

// ===== bench/target_id_allocator_test.sv =====
// Self-checking bench for the paged ID allocator: predicted answers and renumbers vs the block.
`timescale 1ns / 1ps
`default_nettype none

class id_table_scoreboard;
	localparam int SPP = 32;
	localparam int NPG = 8;
	localparam int NSL = SPP * NPG;

	logic [15:0]   slot_handle [NSL];
	bit            slot_used [NSL];
	bit            page_open [NPG];
	int            page_count [NPG];
	int            fill_mark [NPG];
	tid_pkg::rsp_t pending_results [$];
	int            errors;
	int            renumbers;
	int            answers;

	function new();
		for (int i = 0; i < NSL; i++) begin
			slot_used[i] = 0;
			slot_handle[i] = '0;
		end
		for (int p = 0; p < NPG; p++) begin
			page_open[p] = 0;
			page_count[p] = 0;
			fill_mark[p] = 0;
		end
		errors = 0;
		renumbers = 0;
		answers = 0;
	endfunction

	function void push(tid_pkg::kind_t k, int idr, int old, logic [15:0] h, bit f, bit l);
		tid_pkg::rsp_t r;
		r.kind = k;
		r.id_res = idr[7:0];
		r.old_id = old[7:0];
		r.handle_res = h;
		r.found = f;
		r.last = l;
		pending_results.push_back(r);
	endfunction

	function void compact_page(int p);
		int base;
		int tail;
		base = p * SPP;
		tail = 0;
		while (tail < SPP && slot_used[base + tail])
			tail++;
		for (int hd = tail + 1; hd < SPP; hd++) begin
			if (slot_used[base + hd]) begin
				slot_handle[base + tail] = slot_handle[base + hd];
				slot_used[base + tail] = 1;
				slot_used[base + hd] = 0;
				push(tid_pkg::KIND_RENUMBER, base + tail, base + hd,
					slot_handle[base + tail], 0, 0);
				tail++;
			end
		end
		fill_mark[p] = tail;
	endfunction

	function int grant_id(logic [15:0] h);
		int spare;
		int s;
		spare = 0;
		for (int p = 1; p < NPG; p++) begin
			if (!page_open[p]) begin
				if (spare == 0)
					spare = p;
				continue;
			end
			if (page_count[p] >= SPP)
				continue;
			if (fill_mark[p] >= SPP)
				compact_page(p);
			if (fill_mark[p] >= SPP)
				continue;
			s = p * SPP + fill_mark[p];
			slot_handle[s] = h;
			slot_used[s] = 1;
			page_count[p]++;
			fill_mark[p]++;
			return s;
		end
		if (spare == 0)
			return 0;
		for (int i = 0; i < SPP; i++)
			slot_used[spare * SPP + i] = 0;
		page_open[spare] = 1;
		slot_handle[spare * SPP] = h;
		slot_used[spare * SPP] = 1;
		page_count[spare] = 1;
		fill_mark[spare] = 1;
		return spare * SPP;
	endfunction

	function void note_request(tid_pkg::req_t q);
		int  id;
		int  p;
		int  s;
		int  g;
		bit  ok;
		id = q.id;
		ok = id != 0 && id < NSL;
		p = ok ? id / SPP : 0;
		s = ok ? id % SPP : 0;
		case (q.command)
			tid_pkg::CMD_ALLOC: begin
				g = grant_id(q.handle);
				push(tid_pkg::KIND_ANSWER, g, 0, '0, 0, 1);
			end
			tid_pkg::CMD_USE: begin
				if (!ok) begin
					g = grant_id(q.handle);
				end else begin
					if (!page_open[p]) begin
						for (int i = 0; i < SPP; i++)
							slot_used[p * SPP + i] = 0;
						page_open[p] = 1;
						page_count[p] = 0;
						fill_mark[p] = 0;
					end
					if (slot_used[id]) begin
						g = grant_id(q.handle);
					end else begin
						slot_handle[id] = q.handle;
						slot_used[id] = 1;
						page_count[p]++;
						if (fill_mark[p] <= s)
							fill_mark[p] = s + 1;
						g = id;
					end
				end
				push(tid_pkg::KIND_ANSWER, g, 0, '0, 0, 1);
			end
			tid_pkg::CMD_FREE: begin
				if (ok && page_open[p] && slot_used[id]) begin
					slot_used[id] = 0;
					if (page_count[p] > 0)
						page_count[p]--;
					if (page_count[p] == 0) begin
						page_open[p] = 0;
						fill_mark[p] = 0;
					end else if (fill_mark[p] == s + 1) begin
						fill_mark[p] = s;
					end
				end
				push(tid_pkg::KIND_ANSWER, 0, 0, '0, 0, 1);
			end
			default: begin
				if (ok && page_open[p] && slot_used[id])
					push(tid_pkg::KIND_ANSWER, 0, 0, slot_handle[id], 1, 1);
				else
					push(tid_pkg::KIND_ANSWER, 0, 0, '0, 0, 1);
			end
		endcase
	endfunction

	function void check_result(tid_pkg::rsp_t got);
		tid_pkg::rsp_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (got.kind) renumbers++; else answers++;
		if (got.kind !== want.kind)
			$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
		if (got.id_res !== want.id_res)
			$display("%0t: id_res expected %0d actual %0d", $time, want.id_res, got.id_res);
		if (got.old_id !== want.old_id)
			$display("%0t: old_id expected %0d actual %0d", $time, want.old_id, got.old_id);
		if (got.handle_res !== want.handle_res)
			$display("%0t: handle_res expected %h actual %h", $time,
				want.handle_res, got.handle_res);
		if (got.found !== want.found)
			$display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
		if (got.last !== want.last)
			$display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
		if (got !== want)
			errors++;
	endfunction
endclass

module target_id_allocator_test;
	import tid_pkg::*;

	logic  clk = 0;
	logic  arst_n = 0;
	logic  start = 0;
	logic  busy;
	req_t  req = '0;
	logic  done;
	rsp_t  rsp;
	int    cycle_count = 0;
	int    sent = 0;
	id_table_scoreboard board;

	target_id_allocator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			board.check_result(rsp);

	task automatic send_request(cmd_t c, logic [15:0] h, logic [7:0] id);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 0;
			req <= '{command: cmd_t'($urandom_range(0, 3)), handle: 16'($urandom),
				id: 8'($urandom)};
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		req <= '{command: c, handle: h, id: id};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(req);
		sent++;
	endtask

	function automatic logic [7:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'($urandom);
		if (r < 4)
			return 8'($urandom_range(1, 31));
		return 8'($urandom_range(32, 32 + 6 * 8));
	endfunction

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_request(CMD_FIND, 16'h0000, 8'd0);
		send_request(CMD_FREE, 16'h0000, 8'd255);
		send_request(CMD_ALLOC, 16'hFFFF, 8'd0);
		send_request(CMD_USE, 16'h1234, 8'd0);
		send_request(CMD_USE, 16'hABCD, 8'd5);
		send_request(CMD_USE, 16'h5555, 8'd5);
		send_request(CMD_USE, 16'hAAAA, 8'd255);
		send_request(CMD_FIND, 16'h0000, 8'd5);
		send_request(CMD_FIND, 16'h0000, 8'd255);
		send_request(CMD_FIND, 16'h0000, 8'd6);
		send_request(CMD_FREE, 16'h0000, 8'd6);
		send_request(CMD_FREE, 16'h0000, 8'd5);
		send_request(CMD_FIND, 16'h0000, 8'd5);
		send_request(CMD_USE, 16'h0F0F, 8'd200);
		send_request(CMD_FREE, 16'h0000, 8'd200);
		send_request(CMD_FREE, 16'h0000, 8'd32);
		// fill page 1 to its end, punch holes, then allocate to force compaction
		for (int i = 0; i < 32; i++)
			send_request(CMD_ALLOC, 16'($urandom), 8'd0);
		send_request(CMD_FREE, 16'h0000, 8'd33);
		send_request(CMD_FREE, 16'h0000, 8'd40);
		send_request(CMD_FREE, 16'h0000, 8'd50);
		send_request(CMD_ALLOC, 16'h7777, 8'd0);
		send_request(CMD_FIND, 16'h0000, 8'd62);
		// random mix, allocate-heavy to fill pages, then a final run of mostly frees
		for (int i = 0; i < 100; i++) begin
			int r;
			r = $urandom_range(0, 9);
			if (i % 100 >= 70)
				send_request(r < 7 ? CMD_FREE : CMD_FIND, 16'($urandom), pick_id());
			else if (r < 5)
				send_request(CMD_ALLOC, 16'($urandom), 8'($urandom));
			else if (r < 6)
				send_request(CMD_USE, 16'($urandom), pick_id());
			else if (r < 8)
				send_request(CMD_FREE, 16'($urandom), pick_id());
			else
				send_request(CMD_FIND, 16'($urandom), pick_id());
		end
		start <= 0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d requests; saw %0d answers and %0d renumber notices.",
			sent, board.answers, board.renumbers);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/tid_pkg.sv
hw/rtl/tid_ram.sv
hw/rtl/target_id_allocator.sv
bench/target_id_allocator_test.sv
